FILE: src/utf_to_codepoint_decoder_macros.svh
// assertion macros for the utf_to_codepoint_decoder block
// included by the top level, no other dependencies
`ifndef UTF_TO_CODEPOINT_DECODER_MACROS_SVH
`define UTF_TO_CODEPOINT_DECODER_MACROS_SVH

// condition holds at every rising clock edge out of reset
`define UTF_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("utf decoder: invariant violated");

// condition in one cycle implies consequence in the next
`define UTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("utf decoder: sequence violated");

`endif

FILE: src/utf_dec_pkg.sv
// shared types and constants for the utf to code point decoder
// no dependencies
`timescale 1ns / 1ps

package utf_dec_pkg;

    // source encoding codes
    localparam logic [2:0] ENC_UTF8    = 3'd0;
    localparam logic [2:0] ENC_UTF16BE = 3'd1;
    localparam logic [2:0] ENC_UTF16LE = 3'd2;
    localparam logic [2:0] ENC_UTF32BE = 3'd3;
    localparam logic [2:0] ENC_UTF32LE = 3'd4;

    // register index of source_encoding
    localparam logic REG_SOURCE_ENCODING = 1'b0;

    // input op codes
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // surrogate constants
    localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
    localparam logic [31:0] SUPP_BASE     = 32'h0001_0000;

    // default output queue depth (power of two, at least 2)
    localparam int FIFO_DEPTH_DEFAULT = 4;

    typedef struct packed {
        logic [31:0] code_point;
        logic        lone_surrogate;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [2:0] source_encoding;
        logic       clear;
    } cfg_t;

    typedef struct packed {
        logic       pending_valid;
        logic [1:0] bytes_collected;
    } core_status_t;

endpackage

FILE: src/utf_to_codepoint_decoder.sv
// utf-8 / utf-16 / utf-32 to code point decoder, one byte per cycle while the result
// queue has room for two results. each byte passes the input register, then is decoded
// into the result queue, which drives the result word.
// a byte that yields two results pushes both at once into the result queue of
// FIFO_DEPTH entries, and they leave it one after the other.
// reset: asynchronous active low, clears decode state, queue, and encoding (utf-8)
`timescale 1ns / 1ps

`include "utf_to_codepoint_decoder_macros.svh"

module utf_to_codepoint_decoder
#(
    parameter int FIFO_DEPTH = utf_dec_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] op
    // result word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] code_point
    output logic        m_tuser,    // [0] lone_surrogate
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    utf_dec_pkg::cfg_t          cfg;
    utf_dec_pkg::result_t       res0, res1, rd;
    utf_dec_pkg::core_status_t  status;
    logic [1:0]                 push_cnt;
    logic                       room2;
    logic                       not_empty;
    logic [CNT_W-1:0]           count;
    logic                       advance;
    logic                       pop;

    logic                       in_valid_reg;
    logic                       in_op_reg;
    logic [7:0]                 in_byte_reg;

    logic                       flush_taken;
    logic                       core_idle;

    // configuration register
    utf_dec_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register
    assign advance  = in_valid_reg && room2;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // decode
    utf_dec_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .advance   (advance),
        .op        (in_op_reg),
        .data_byte (in_byte_reg),
        .push_cnt  (push_cnt),
        .res0      (res0),
        .res1      (res1),
        .status    (status)
    );

    // result queue
    assign pop = not_empty && m_tready;

    utf_dec_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .wr0       (res0),
        .wr1       (res1),
        .pop       (pop),
        .rd        (rd),
        .not_empty (not_empty),
        .room2     (room2),
        .count     (count)
    );

    assign m_tvalid = not_empty;
    assign m_tdata  = rd.code_point;
    assign m_tuser  = rd.lone_surrogate;
    assign m_tlast  = rd.last_of_run;

    // flush word taken by the decoder, and decoder holding nothing
    assign flush_taken = advance && in_op_reg && !cfg.clear;
    assign core_idle   = !status.pending_valid && (status.bytes_collected == 2'd0);

    // checks
    `UTF_ASSERT_ALWAYS(a_queue_bound, clk, rst_n, count <= CNT_W'(FIFO_DEPTH))
    `UTF_ASSERT_ALWAYS(a_push_fits, clk, rst_n, (push_cnt == 2'd0) || room2)
    `UTF_ASSERT_NEXT(a_flush_clears, clk, rst_n, flush_taken, core_idle)

endmodule

FILE: src/utf_dec_cfg.sv
// apb-style configuration register for the source encoding
// depends on utf_dec_pkg
`timescale 1ns / 1ps

module utf_dec_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output utf_dec_pkg::cfg_t   cfg
);

    logic [2:0] enc_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready
                    && (paddr[2] == utf_dec_pkg::REG_SOURCE_ENCODING);

    // encoding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg <= utf_dec_pkg::ENC_UTF8;
        end
        else if (wr_en)
        begin
            enc_reg <= pwdata[2:0];
        end
    end

    // read back
    assign prdata = (paddr[2] == utf_dec_pkg::REG_SOURCE_ENCODING) ?
                    {29'b0, enc_reg} : 32'b0;

    assign cfg.source_encoding = enc_reg;
    assign cfg.clear           = wr_en;

endmodule

FILE: src/utf_dec_core.sv
// decode state and single-pass decode logic, up to two results per byte
// depends on utf_dec_pkg
`timescale 1ns / 1ps

module utf_dec_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  utf_dec_pkg::cfg_t           cfg,
    input  logic                        advance,
    input  logic                        op,
    input  logic [7:0]                  data_byte,
    output logic [1:0]                  push_cnt,
    output utf_dec_pkg::result_t        res0,
    output utf_dec_pkg::result_t        res1,
    output utf_dec_pkg::core_status_t   status
);

    logic [31:0] acc_reg,  acc_next;
    logic [1:0]  coll_reg, coll_next;
    logic [2:0]  exp_reg,  exp_next;
    logic [9:0]  ph_reg,   ph_next;
    logic        pv_reg,   pv_next;

    logic [1:0]  n;
    logic [31:0] cp0, cp1;
    logic        lone0, lone1;

    // decode of one item against the current state
    always_comb
    begin
        logic [15:0] u16;
        logic [31:0] acc_cont;
        logic        is_high, is_low;

        acc_next  = acc_reg;
        coll_next = coll_reg;
        exp_next  = exp_reg;
        ph_next   = ph_reg;
        pv_next   = pv_reg;
        n         = 2'd0;
        cp0       = '0;
        cp1       = '0;
        lone0     = 1'b0;
        lone1     = 1'b0;

        u16 = (cfg.source_encoding == utf_dec_pkg::ENC_UTF16BE) ?
              {acc_reg[7:0], data_byte} : {data_byte, acc_reg[7:0]};
        is_high  = (u16[15:10] == utf_dec_pkg::SURR_HIGH_TAG);
        is_low   = (u16[15:10] == utf_dec_pkg::SURR_LOW_TAG);
        acc_cont = {acc_reg[25:0], data_byte[5:0]};

        if (op == utf_dec_pkg::OP_FLUSH)
        begin
            // release a waiting surrogate, drop partial bytes
            if (pv_reg)
            begin
                n     = 2'd1;
                cp0   = {16'h0, utf_dec_pkg::SURR_HIGH_TAG, ph_reg};
                lone0 = 1'b1;
            end
            acc_next  = '0;
            coll_next = '0;
            exp_next  = '0;
            ph_next   = '0;
            pv_next   = 1'b0;
        end
        else
        begin
            unique case (cfg.source_encoding) inside
                utf_dec_pkg::ENC_UTF8:
                begin
                    if (coll_reg == 2'd0)
                    begin
                        if (!data_byte[7])
                        begin
                            n   = 2'd1;
                            cp0 = {24'h0, data_byte};
                        end
                        else
                        begin
                            coll_next = 2'd1;
                            if (!data_byte[5])
                            begin
                                exp_next = 3'd2;
                                acc_next = {27'h0, data_byte[4:0]};
                            end
                            else if (!data_byte[4])
                            begin
                                exp_next = 3'd3;
                                acc_next = {28'h0, data_byte[3:0]};
                            end
                            else
                            begin
                                exp_next = 3'd4;
                                acc_next = {29'h0, data_byte[2:0]};
                            end
                        end
                    end
                    else if (({1'b0, coll_reg} + 3'd1) >= exp_reg)
                    begin
                        n         = 2'd1;
                        cp0       = acc_cont;
                        acc_next  = '0;
                        coll_next = '0;
                        exp_next  = '0;
                    end
                    else
                    begin
                        acc_next  = acc_cont;
                        coll_next = coll_reg + 2'd1;
                    end
                end
                utf_dec_pkg::ENC_UTF16BE, utf_dec_pkg::ENC_UTF16LE:
                begin
                    if (coll_reg == 2'd0)
                    begin
                        acc_next  = {24'h0, data_byte};
                        coll_next = 2'd1;
                    end
                    else
                    begin
                        acc_next  = '0;
                        coll_next = '0;
                        if (pv_reg && is_low)
                        begin
                            // surrogate pair completes
                            n       = 2'd1;
                            cp0     = {12'h0, ph_reg, u16[9:0]} + utf_dec_pkg::SUPP_BASE;
                            ph_next = '0;
                            pv_next = 1'b0;
                        end
                        else if (pv_reg)
                        begin
                            // waiting surrogate goes out alone first
                            cp0   = {16'h0, utf_dec_pkg::SURR_HIGH_TAG, ph_reg};
                            lone0 = 1'b1;
                            if (is_high)
                            begin
                                n       = 2'd1;
                                ph_next = u16[9:0];
                                pv_next = 1'b1;
                            end
                            else
                            begin
                                n       = 2'd2;
                                cp1     = {16'h0, u16};
                                ph_next = '0;
                                pv_next = 1'b0;
                            end
                        end
                        else if (is_high)
                        begin
                            ph_next = u16[9:0];
                            pv_next = 1'b1;
                        end
                        else
                        begin
                            n   = 2'd1;
                            cp0 = {16'h0, u16};
                        end
                    end
                end
                utf_dec_pkg::ENC_UTF32BE, utf_dec_pkg::ENC_UTF32LE:
                begin
                    if (cfg.source_encoding == utf_dec_pkg::ENC_UTF32BE)
                    begin
                        acc_next = {acc_reg[23:0], data_byte};
                    end
                    else
                    begin
                        acc_next = acc_reg | ({24'h0, data_byte} << {coll_reg, 3'b000});
                    end
                    if (coll_reg == 2'd3)
                    begin
                        n         = 2'd1;
                        cp0       = acc_next;
                        acc_next  = '0;
                        coll_next = '0;
                    end
                    else
                    begin
                        coll_next = coll_reg + 2'd1;
                    end
                end
                default:
                begin
                    // unknown encoding: byte dropped
                    n = 2'd0;
                end
            endcase
        end
    end

    // decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            coll_reg <= '0;
            exp_reg  <= '0;
            ph_reg   <= '0;
            pv_reg   <= 1'b0;
        end
        else if (cfg.clear)
        begin
            acc_reg  <= '0;
            coll_reg <= '0;
            exp_reg  <= '0;
            ph_reg   <= '0;
            pv_reg   <= 1'b0;
        end
        else if (advance)
        begin
            acc_reg  <= acc_next;
            coll_reg <= coll_next;
            exp_reg  <= exp_next;
            ph_reg   <= ph_next;
            pv_reg   <= pv_next;
        end
    end

    assign push_cnt = advance ? n : 2'd0;

    assign res0.code_point     = cp0;
    assign res0.lone_surrogate = lone0;
    assign res0.last_of_run    = (n == 2'd1);
    assign res1.code_point     = cp1;
    assign res1.lone_surrogate = lone1;
    assign res1.last_of_run    = 1'b1;

    assign status.pending_valid   = pv_reg;
    assign status.bytes_collected = coll_reg;

endmodule

FILE: src/utf_dec_fifo.sv
// result queue taking up to two words per cycle, one out per cycle
// depends on utf_dec_pkg
`timescale 1ns / 1ps

module utf_dec_fifo
#(
    parameter int DEPTH = utf_dec_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [1:0]                      push_cnt,
    input  utf_dec_pkg::result_t            wr0,
    input  utf_dec_pkg::result_t            wr1,
    input  logic                            pop,
    output utf_dec_pkg::result_t            rd,
    output logic                            not_empty,
    output logic                            room2,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    utf_dec_pkg::result_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [PTR_W-1:0]       wr_ptr_p1;

    assign wr_ptr_p1 = wr_ptr_reg + PTR_W'(1);

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= wr0;
        end
        if (push_cnt == 2'd2)
        begin
            entry_reg[wr_ptr_p1] <= wr1;
        end
    end

    // occupancy
    always_comb
    begin
        count_next = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    assign rd        = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room2     = (count_reg <= CNT_W'(DEPTH - 2));
    assign count     = count_reg;

endmodule

FILE: tb/sv/tb.sv
// testbench for utf_to_codepoint_decoder: byte words in, code point words out,
// results predicted per accepted byte and checked in order against the block
// depends on utf_dec_pkg and the utf_to_codepoint_decoder rtl
`timescale 1ns / 1ps

module tb;

    // register addresses, one 32-bit register per 4 bytes
    localparam logic [2:0] ENC_ADDR    = {2'b00, utf_dec_pkg::REG_SOURCE_ENCODING} << 2;
    localparam logic [2:0] UNUSED_ADDR = 3'd4;

    // surrogate ranges
    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;

    localparam int IDLE_LIMIT   = 1000;
    localparam int SETTLE_WAIT  = 8;
    localparam int PHASE_WORDS  = 190;
    localparam int IGNORE_WORDS = 20;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } in_word_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    utf_to_codepoint_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // pending byte words and expected code point words
    in_word_t             byte_queue[$];
    utf_dec_pkg::result_t cp_expected[$];
    int                   words_queued = 0;
    int                   n_errors = 0;

    // decoder state as predicted
    logic [2:0]  enc_sel = utf_dec_pkg::ENC_UTF8;
    logic [31:0] unit_acc = 32'd0;
    logic [1:0]  n_got = 2'd0;
    logic [2:0]  n_need = 3'd0;
    logic [9:0]  hi_bits = 10'd0;
    logic        hi_wait = 1'b0;

    // handshake flags seen at the last rising edge
    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    int   idle_cycles = 0;
    bit   no_idle = 1'b0;
    bit   no_stall = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        n_errors++;
    endtask

    // ---------------- code point prediction ----------------

    task automatic clear_units();
        unit_acc = 32'd0;
        n_got = 2'd0;
        n_need = 3'd0;
        hi_bits = 10'd0;
        hi_wait = 1'b0;
    endtask

    task automatic add_code_point(input logic [31:0] cp, input logic lone);
        utf_dec_pkg::result_t r;
        r.code_point = cp;
        r.lone_surrogate = lone;
        r.last_of_run = 1'b0;
        cp_expected.push_back(r);
    endtask

    // one complete utf-16 unit, pairing surrogates
    task automatic take_utf16_unit(input logic [15:0] u);
        logic is_hi;
        logic is_lo;
        is_hi = (u >= HIGH_FIRST) && (u <= HIGH_LAST);
        is_lo = (u >= LOW_FIRST) && (u <= LOW_LAST);
        if (hi_wait)
        begin
            if (is_lo)
            begin
                add_code_point(32'({hi_bits, u[9:0]}) + utf_dec_pkg::SUPP_BASE, 1'b0);
                hi_wait = 1'b0;
                hi_bits = 10'd0;
                return;
            end
            add_code_point(32'(HIGH_FIRST) | 32'(hi_bits), 1'b1);
            hi_wait = 1'b0;
            hi_bits = 10'd0;
        end
        if (is_hi)
        begin
            hi_bits = u[9:0];
            hi_wait = 1'b1;
        end
        else
            add_code_point(32'(u), 1'b0);
    endtask

    // advance the predicted state by one accepted byte word
    task automatic decode_word(input logic op, input logic [7:0] b);
        int                   n_before;
        logic [15:0]          u;
        utf_dec_pkg::result_t r;
        n_before = cp_expected.size();
        if (op == utf_dec_pkg::OP_FLUSH)
        begin
            if (hi_wait)
                add_code_point(32'(HIGH_FIRST) | 32'(hi_bits), 1'b1);
            clear_units();
        end
        else
        begin
            case (enc_sel)
                utf_dec_pkg::ENC_UTF8:
                    if (n_got == 2'd0)
                    begin
                        if (!b[7])
                            add_code_point(32'(b), 1'b0);
                        else
                        begin
                            // length from the lead byte alone
                            if (!b[5])
                            begin
                                n_need = 3'd2;
                                unit_acc = 32'(b[4:0]);
                            end
                            else if (!b[4])
                            begin
                                n_need = 3'd3;
                                unit_acc = 32'(b[3:0]);
                            end
                            else
                            begin
                                n_need = 3'd4;
                                unit_acc = 32'(b[2:0]);
                            end
                            n_got = 2'd1;
                        end
                    end
                    else
                    begin
                        unit_acc = (unit_acc << 6) | 32'(b[5:0]);
                        if (int'(n_got) + 1 >= int'(n_need))
                        begin
                            add_code_point(unit_acc, 1'b0);
                            unit_acc = 32'd0;
                            n_got = 2'd0;
                            n_need = 3'd0;
                        end
                        else
                            n_got = n_got + 2'd1;
                    end
                utf_dec_pkg::ENC_UTF16BE, utf_dec_pkg::ENC_UTF16LE:
                    if (n_got == 2'd0)
                    begin
                        unit_acc = 32'(b);
                        n_got = 2'd1;
                    end
                    else
                    begin
                        if (enc_sel == utf_dec_pkg::ENC_UTF16BE)
                            u = {unit_acc[7:0], b};
                        else
                            u = {b, unit_acc[7:0]};
                        unit_acc = 32'd0;
                        n_got = 2'd0;
                        take_utf16_unit(u);
                    end
                utf_dec_pkg::ENC_UTF32BE, utf_dec_pkg::ENC_UTF32LE:
                begin
                    if (enc_sel == utf_dec_pkg::ENC_UTF32BE)
                        unit_acc = {unit_acc[23:0], b};
                    else
                        unit_acc = unit_acc | (32'(b) << {n_got, 3'b000});
                    if (n_got == 2'd3)
                    begin
                        add_code_point(unit_acc, 1'b0);
                        unit_acc = 32'd0;
                        n_got = 2'd0;
                    end
                    else
                        n_got = n_got + 2'd1;
                end
                default:
                    ;
            endcase
        end
        // mark the final result of this byte
        if (cp_expected.size() > n_before)
        begin
            r = cp_expected.pop_back();
            r.last_of_run = 1'b1;
            cp_expected.push_back(r);
        end
    endtask

    // ---------------- stimulus generation ----------------

    task automatic push_word(input logic op, input logic [7:0] d);
        in_word_t w;
        w.op = op;
        w.data = d;
        byte_queue.push_back(w);
        words_queued++;
    endtask

    // continuation byte, top bits sometimes broken since they are not checked
    function automatic logic [7:0] cont_byte(input logic [5:0] bits);
        if ($urandom_range(0, 3) == 0)
            return {2'($urandom), bits};
        return {2'b10, bits};
    endfunction

    task automatic gen_utf8_char();
        logic [20:0] cp;
        case ($urandom_range(0, 3))
            0:
            begin
                cp = 21'($urandom_range(0, 'h7F));
                push_word(utf_dec_pkg::OP_DATA, cp[7:0]);
            end
            1:
            begin
                cp = 21'($urandom_range('h80, 'h7FF));
                push_word(utf_dec_pkg::OP_DATA, {3'b110, cp[10:6]});
                push_word(utf_dec_pkg::OP_DATA, cont_byte(cp[5:0]));
            end
            2:
            begin
                cp = 21'($urandom_range('h800, 'hFFFF));
                push_word(utf_dec_pkg::OP_DATA, {4'b1110, cp[15:12]});
                push_word(utf_dec_pkg::OP_DATA, cont_byte(cp[11:6]));
                push_word(utf_dec_pkg::OP_DATA, cont_byte(cp[5:0]));
            end
            default:
            begin
                cp = 21'($urandom_range('h10000, 'h1FFFFF));
                push_word(utf_dec_pkg::OP_DATA, {5'b11110, cp[20:18]});
                push_word(utf_dec_pkg::OP_DATA, cont_byte(cp[17:12]));
                push_word(utf_dec_pkg::OP_DATA, cont_byte(cp[11:6]));
                push_word(utf_dec_pkg::OP_DATA, cont_byte(cp[5:0]));
            end
        endcase
    endtask

    task automatic push_unit16(input bit big_end, input logic [15:0] u);
        if (big_end)
        begin
            push_word(utf_dec_pkg::OP_DATA, u[15:8]);
            push_word(utf_dec_pkg::OP_DATA, u[7:0]);
        end
        else
        begin
            push_word(utf_dec_pkg::OP_DATA, u[7:0]);
            push_word(utf_dec_pkg::OP_DATA, u[15:8]);
        end
    endtask

    task automatic gen_utf16_unit(input bit big_end);
        int k;
        k = $urandom_range(0, 9);
        if (k < 5)
            push_unit16(big_end, 16'($urandom));
        else if (k < 8)
        begin
            // well-formed pair
            push_unit16(big_end, HIGH_FIRST + 16'($urandom_range(0, 'h3FF)));
            push_unit16(big_end, LOW_FIRST + 16'($urandom_range(0, 'h3FF)));
        end
        else if (k == 8)
            push_unit16(big_end, HIGH_FIRST + 16'($urandom_range(0, 'h3FF)));
        else
            push_unit16(big_end, LOW_FIRST + 16'($urandom_range(0, 'h3FF)));
    endtask

    task automatic gen_utf32_word(input bit big_end);
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = 32'd0;
            1: v = 32'hFFFF_FFFF;
            2: v = 32'($urandom_range(0, 'h10FFFF));
            default: v = $urandom;
        endcase
        if (big_end)
            for (int i = 3; i >= 0; i--)
                push_word(utf_dec_pkg::OP_DATA, v[i*8 +: 8]);
        else
            for (int i = 0; i < 4; i++)
                push_word(utf_dec_pkg::OP_DATA, v[i*8 +: 8]);
    endtask

    // mostly well-formed units, some stray bytes and flushes
    task automatic fill_random_phase(input logic [2:0] enc, input int count);
        int stop_at;
        int r;
        stop_at = words_queued + count;
        while (words_queued < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                push_word(utf_dec_pkg::OP_FLUSH, 8'($urandom));
            else if (r < 12)
                push_word(utf_dec_pkg::OP_DATA, 8'($urandom));
            else
                case (enc)
                    utf_dec_pkg::ENC_UTF8:    gen_utf8_char();
                    utf_dec_pkg::ENC_UTF16BE: gen_utf16_unit(1'b1);
                    utf_dec_pkg::ENC_UTF16LE: gen_utf16_unit(1'b0);
                    utf_dec_pkg::ENC_UTF32BE: gen_utf32_word(1'b1);
                    utf_dec_pkg::ENC_UTF32LE: gen_utf32_word(1'b0);
                    default:     push_word(utf_dec_pkg::OP_DATA, 8'($urandom));
                endcase
        end
    endtask

    // ---------------- configuration access ----------------

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // a write clears partial units, other addresses are ignored
        if (addr == ENC_ADDR)
        begin
            enc_sel = val[2:0];
            clear_units();
        end
    endtask

    task automatic apb_check_encoding();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ENC_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[2:0] !== enc_sel)
            report_mismatch($sformatf("encoding reads %h, wanted %h", prdata[2:0], enc_sel));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_encoding(input logic [2:0] enc);
        apb_write(ENC_ADDR, {29'($urandom), enc});
        apb_check_encoding();
    endtask

    // wait until every queued byte is taken and every result has come
    task automatic drain();
        do
            @(posedge clk);
        while (byte_queue.size() != 0 || s_tvalid || cp_expected.size() != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // ---------------- input driver ----------------

    always @(negedge clk)
    begin : byte_driver
        in_word_t w;
        int       gap_left;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end
        else if (s_tvalid && !in_fire)
            ;
        else if (gap_left > 0)
        begin
            s_tvalid <= 1'b0;
            gap_left--;
        end
        else if (byte_queue.size() != 0)
        begin
            w = byte_queue.pop_front();
            s_tdata <= w.data;
            s_tuser <= w.op;
            s_tvalid <= 1'b1;
            gap_left = no_idle ? 0 : $urandom_range(0, 4);
        end
        else
            s_tvalid <= 1'b0;
    end

    // ---------------- output ready ----------------

    always @(negedge clk)
    begin : result_sink
        int stall_left;
        int s;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else if (out_fire)
        begin
            s = no_stall ? 0 : $urandom_range(0, 4);
            stall_left = (s > 0) ? s - 1 : 0;
            m_tready <= (s == 0);
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // ---------------- monitor and checker ----------------

    always @(posedge clk)
    begin : word_monitor
        utf_dec_pkg::result_t want;
        logic                 took_in;
        logic                 took_out;
        took_in = s_tvalid && s_tready;
        took_out = m_tvalid && m_tready;
        if (!rst_n)
        begin
            in_fire <= 1'b0;
            out_fire <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            in_fire <= took_in;
            out_fire <= took_out;
            // compare a taken result with the oldest expectation
            if (took_out)
            begin
                if (cp_expected.size() == 0)
                    report_mismatch($sformatf("unexpected code point %h", m_tdata));
                else
                begin
                    want = cp_expected.pop_front();
                    if (m_tdata !== want.code_point)
                        report_mismatch($sformatf("code point %h, wanted %h",
                                                  m_tdata, want.code_point));
                    if (m_tuser !== want.lone_surrogate)
                        report_mismatch($sformatf("lone surrogate %b, wanted %b for %h",
                                                  m_tuser, want.lone_surrogate,
                                                  want.code_point));
                    if (m_tlast !== want.last_of_run)
                        report_mismatch($sformatf("last %b, wanted %b for %h",
                                                  m_tlast, want.last_of_run,
                                                  want.code_point));
                end
            end
            if (took_in)
                decode_word(s_tuser, s_tdata);
            // watchdog on cycles without any word moving
            if (took_in || took_out)
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("tb failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- test sequence ----------------

    initial
    begin : test_sequence
        logic [2:0] enc;
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // utf-8 at the reset encoding: ascii extremes, four-byte form,
        // stray continuation lead, lead 0xff, partial unit dropped by flush
        push_word(utf_dec_pkg::OP_DATA, 8'h00);
        push_word(utf_dec_pkg::OP_DATA, 8'h7F);
        push_word(utf_dec_pkg::OP_DATA, 8'hF0);
        push_word(utf_dec_pkg::OP_DATA, 8'h9F);
        push_word(utf_dec_pkg::OP_DATA, 8'h98);
        push_word(utf_dec_pkg::OP_DATA, 8'h80);
        push_word(utf_dec_pkg::OP_DATA, 8'h80);
        push_word(utf_dec_pkg::OP_DATA, 8'h3F);
        push_word(utf_dec_pkg::OP_DATA, 8'hFF);
        push_word(utf_dec_pkg::OP_DATA, 8'hBF);
        push_word(utf_dec_pkg::OP_DATA, 8'hBF);
        push_word(utf_dec_pkg::OP_DATA, 8'hBF);
        push_word(utf_dec_pkg::OP_DATA, 8'hE2);
        push_word(utf_dec_pkg::OP_FLUSH, 8'hFF);
        drain();
        apb_check_encoding();

        // utf-16be: highest pair, high after high, flush releasing a high
        set_encoding(utf_dec_pkg::ENC_UTF16BE);
        push_unit16(1'b1, HIGH_LAST);
        push_unit16(1'b1, LOW_LAST);
        push_unit16(1'b1, HIGH_FIRST);
        push_unit16(1'b1, HIGH_FIRST);
        push_word(utf_dec_pkg::OP_FLUSH, 8'h00);
        drain();

        // utf-16le: lone low surrogate, then an ignored write mid-unit
        set_encoding(utf_dec_pkg::ENC_UTF16LE);
        push_unit16(1'b0, LOW_FIRST);
        push_word(utf_dec_pkg::OP_DATA, 8'h3D);
        drain();
        apb_write(UNUSED_ADDR, $urandom);
        apb_check_encoding();
        push_word(utf_dec_pkg::OP_DATA, 8'hD8);
        push_word(utf_dec_pkg::OP_FLUSH, 8'h00);
        drain();

        // random phases over every encoding value, each twice
        for (int p = 0; p < 16; p++)
        begin
            enc = 3'(p);
            no_idle = ($urandom_range(0, 3) == 0);
            no_stall = ($urandom_range(0, 3) == 0);
            set_encoding(enc);
            fill_random_phase(enc, (enc <= utf_dec_pkg::ENC_UTF32LE) ?
                                   PHASE_WORDS : IGNORE_WORDS);
            drain();
        end

        if (n_errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/utf_dec_pkg.sv
src/utf_dec_cfg.sv
src/utf_dec_core.sv
src/utf_dec_fifo.sv
src/utf_to_codepoint_decoder.sv
tb/sv/tb.sv
